// File: hw/rtl/bra_pkg.sv
// Shared types and constants for the bitmap run allocator.
`default_nettype none
package bra_pkg;

  localparam int NBITS     = 1024;
  localparam int WORD_BITS = 32;
  localparam int NWORDS    = NBITS / WORD_BITS;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int WADDR_W   = 5;
  localparam int BIT_W     = 5;
  localparam int ADDR_W    = 3;

  localparam logic [CNT_W-1:0]  NBITS_C       = CNT_W'(NBITS);
  localparam logic [ADDR_W-1:0] REG_LIMIT_ADR = 3'd0;

  localparam logic [2:0] OP_SET   = 3'd0;
  localparam logic [2:0] OP_CLR   = 3'd1;
  localparam logic [2:0] OP_TEST  = 3'd2;
  localparam logic [2:0] OP_RANGE = 3'd3;
  localparam logic [2:0] OP_FIT   = 3'd4;
  localparam logic [2:0] OP_ONE   = 3'd5;

  typedef struct packed {
    logic [2:0]       op;
    logic [IDX_W-1:0] bit_index;
    logic [CNT_W-1:0] bit_count;
  } cmd_t;

  typedef struct packed {
    logic             bit_value;
    logic [IDX_W-1:0] found_index;
    logic             status;
  } res_t;

endpackage
`default_nettype wire

// File: hw/rtl/bra_engine.sv
// Bitmap memory with the scan / read-modify-write sequencer.
`default_nettype none
module bra_engine (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cmd_valid,
  input  wire bra_pkg::cmd_t             cmd,
  output logic                           cmd_ready,
  input  wire logic [bra_pkg::CNT_W-1:0] lim,
  output logic                           res_valid,
  output bra_pkg::res_t                  res,
  input  wire logic                      res_ready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD  = 3'd1;
  localparam logic [2:0] ST_FIT  = 3'd2;
  localparam logic [2:0] ST_ONE  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [1:0] MD_SET  = 2'd0;
  localparam logic [1:0] MD_CLR  = 2'd1;
  localparam logic [1:0] MD_TEST = 2'd2;

  localparam int W  = bra_pkg::WORD_BITS;
  localparam int AW = bra_pkg::WADDR_W;
  localparam int IW = bra_pkg::IDX_W;
  localparam int CW = bra_pkg::CNT_W;
  localparam int BW = bra_pkg::BIT_W;

  // bitmap storage, per-word valid flags stand in for the reset clear
  logic [W-1:0]              mem [bra_pkg::NWORDS];
  logic [bra_pkg::NWORDS-1:0] vld_r;
  logic [W-1:0]              rd_data_r;
  logic                      rd_vld_r;
  logic                      rd_en, wr_en;
  logic [AW-1:0]             rd_addr, wr_addr;
  logic [W-1:0]              wr_data;

  logic [2:0]    st_r, st_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, run_r, run_nxt;
  logic [AW-1:0] iss_w_r, iss_w_nxt, end_w_r, end_w_nxt, ev_w_r, ev_w_nxt;
  logic          iss_on_r, iss_on_nxt, ev_on_r, ev_on_nxt;
  bra_pkg::res_t res_r, res_nxt;

  logic [W-1:0]  word_d, limmask, used, free, modmask;
  logic [CW-1:0] run_j [W];
  logic          fit_hit, one_hit, any_used;
  logic [BW-1:0] fit_j, one_j, hi_used;
  logic [CW-1:0] run_word, fit_base, fit_end, lim_m1;
  logic [CW:0]   range_end;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign word_d = rd_vld_r ? rd_data_r : '0;
  assign lim_m1 = lim - CW'(1);

  always_comb begin
    for (int j = 0; j < W; j++) begin
      limmask[j] = ({1'b0, ev_w_r, BW'(j)} >= lim);
      modmask[j] = ({ev_w_r, BW'(j)} >= lo_r) && ({ev_w_r, BW'(j)} <= hi_r);
    end
  end

  assign used = word_d | limmask;
  assign free = ~used;

  // free run length ending at each bit position, carried in from lower words
  always_comb begin
    logic          has;
    logic [BW-1:0] p;
    for (int j = 0; j < W; j++) begin
      has = 1'b0;
      p   = '0;
      for (int k = 0; k < W; k++) begin
        if (k <= j && used[k]) begin
          has = 1'b1;
          p   = BW'(k);
        end
      end
      run_j[j] = has ? (CW'(j) - {{(CW-BW){1'b0}}, p}) : (run_r + CW'(j) + CW'(1));
    end
  end

  always_comb begin
    fit_hit = 1'b0;
    fit_j   = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (run_j[j] >= cnt_r) begin
        fit_hit = 1'b1;
        fit_j   = BW'(j);
      end
    end
  end

  always_comb begin
    one_hit  = 1'b0;
    one_j    = '0;
    any_used = 1'b0;
    hi_used  = '0;
    for (int j = 0; j < W; j++) begin
      if (free[j]) begin
        one_hit = 1'b1;
        one_j   = BW'(j);
      end
      if (used[j]) begin
        any_used = 1'b1;
        hi_used  = BW'(j);
      end
    end
  end

  assign run_word  = any_used ? {{(CW-BW){1'b0}}, BW'(W - 1) - hi_used}
                              : run_r + CW'(W);
  assign fit_base  = {1'b0, ev_w_r, fit_j} + CW'(1) - cnt_r;
  assign fit_end   = fit_base + cnt_r - CW'(1);
  assign range_end = {2'b00, cmd.bit_index} + {1'b0, cmd.bit_count} - (CW+1)'(1);

  always_comb begin
    st_nxt     = st_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    run_nxt    = run_r;
    iss_w_nxt  = iss_w_r;
    end_w_nxt  = end_w_r;
    ev_w_nxt   = ev_w_r;
    iss_on_nxt = iss_on_r;
    ev_on_nxt  = ev_on_r;
    res_nxt    = res_r;
    rd_en      = 1'b0;
    rd_addr    = iss_w_r;
    wr_en      = 1'b0;
    wr_addr    = ev_w_r;
    wr_data    = word_d;

    // streaming reads: one word issued per cycle, evaluated the next
    if (st_r == ST_MOD || st_r == ST_FIT || st_r == ST_ONE) begin
      rd_en     = iss_on_r;
      ev_on_nxt = iss_on_r;
      ev_w_nxt  = iss_w_r;
      if (iss_on_r) begin
        if (iss_w_r == end_w_r) begin
          iss_on_nxt = 1'b0;
        end else if (st_r == ST_ONE) begin
          iss_w_nxt = iss_w_r - AW'(1);
        end else begin
          iss_w_nxt = iss_w_r + AW'(1);
        end
      end
    end

    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          res_nxt    = '0;
          lo_nxt     = cmd.bit_index;
          hi_nxt     = cmd.bit_index;
          cnt_nxt    = cmd.bit_count;
          run_nxt    = '0;
          iss_w_nxt  = cmd.bit_index[IW-1:BW];
          end_w_nxt  = cmd.bit_index[IW-1:BW];
          iss_on_nxt = 1'b1;
          ev_on_nxt  = 1'b0;
          st_nxt     = ST_MOD;
          case (cmd.op)
            bra_pkg::OP_SET:  mode_nxt = MD_SET;
            bra_pkg::OP_CLR:  mode_nxt = MD_CLR;
            bra_pkg::OP_TEST: mode_nxt = MD_TEST;
            bra_pkg::OP_RANGE: begin
              mode_nxt = MD_SET;
              if (cmd.bit_count == '0) begin
                st_nxt = ST_DONE;
              end else if (range_end >= (CW+1)'(bra_pkg::NBITS)) begin
                hi_nxt    = IW'(bra_pkg::NBITS - 1);
                end_w_nxt = AW'(bra_pkg::NWORDS - 1);
              end else begin
                hi_nxt    = range_end[IW-1:0];
                end_w_nxt = range_end[IW-1:BW];
              end
            end
            bra_pkg::OP_FIT: begin
              iss_w_nxt = '0;
              end_w_nxt = lim_m1[IW-1:BW];
              if (cmd.bit_count == '0 || lim == '0) begin
                res_nxt.status = 1'b1;
                st_nxt         = ST_DONE;
              end else begin
                st_nxt = ST_FIT;
              end
            end
            bra_pkg::OP_ONE: begin
              iss_w_nxt = lim_m1[IW-1:BW];
              end_w_nxt = '0;
              if (lim == '0) begin
                res_nxt.status = 1'b1;
                st_nxt         = ST_DONE;
              end else begin
                st_nxt = ST_ONE;
              end
            end
            default: st_nxt = ST_DONE;
          endcase
          if (st_nxt == ST_DONE) begin
            iss_on_nxt = 1'b0;
          end
        end
      end
      ST_MOD: begin
        if (ev_on_r) begin
          if (mode_r == MD_TEST) begin
            res_nxt.bit_value = word_d[lo_r[BW-1:0]];
          end else begin
            wr_en   = 1'b1;
            wr_data = (mode_r == MD_CLR) ? (word_d & ~modmask) : (word_d | modmask);
          end
          if (ev_w_r == end_w_r) begin
            st_nxt     = ST_DONE;
            iss_on_nxt = 1'b0;
            ev_on_nxt  = 1'b0;
          end
        end
      end
      ST_FIT: begin
        if (ev_on_r) begin
          if (fit_hit) begin
            res_nxt.found_index = fit_base[IW-1:0];
            lo_nxt     = fit_base[IW-1:0];
            hi_nxt     = fit_end[IW-1:0];
            mode_nxt   = MD_SET;
            iss_w_nxt  = fit_base[IW-1:BW];
            end_w_nxt  = fit_end[IW-1:BW];
            iss_on_nxt = 1'b1;
            ev_on_nxt  = 1'b0;
            st_nxt     = ST_MOD;
          end else begin
            run_nxt = run_word;
            if (ev_w_r == end_w_r) begin
              res_nxt.status = 1'b1;
              st_nxt         = ST_DONE;
              iss_on_nxt     = 1'b0;
              ev_on_nxt      = 1'b0;
            end
          end
        end
      end
      ST_ONE: begin
        if (ev_on_r) begin
          if (one_hit) begin
            wr_en   = 1'b1;
            wr_data = word_d | (W'(1) << one_j);
            res_nxt.found_index = {ev_w_r, one_j};
            st_nxt     = ST_DONE;
            iss_on_nxt = 1'b0;
            ev_on_nxt  = 1'b0;
          end else if (ev_w_r == end_w_r) begin
            res_nxt.status = 1'b1;
            st_nxt         = ST_DONE;
            iss_on_nxt     = 1'b0;
            ev_on_nxt      = 1'b0;
          end
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      iss_on_r <= 1'b0;
      ev_on_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      iss_on_r <= iss_on_nxt;
      ev_on_r  <= ev_on_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mode_r  <= mode_nxt;
    cnt_r   <= cnt_nxt;
    run_r   <= run_nxt;
    iss_w_r <= iss_w_nxt;
    end_w_r <= end_w_nxt;
    ev_w_r  <= ev_w_nxt;
    res_r   <= res_nxt;
  end

  assign cmd_ready = (st_r == ST_IDLE);
  assign res_valid = (st_r == ST_DONE);
  assign res       = res_r;

endmodule
`default_nettype wire

// File: hw/rtl/bitmap_run_allocator_unit.sv
// Top level: stream ports, APB limit register, result output register.
// Time to out_tvalid grows with the work: set/clear/test touch one word; set range grows
// with the words touched; allocate one with the words scanned; allocate run with the words
// scanned plus the words set. One item at a time, the next accepted once the result has
// moved into the output register; the single read and write port of the bitmap memory,
// one word a cycle, set the pace.
// Synchronous reset: bitmap reads as all free at once (per-word valid flags), limit 1024.
`default_nettype none
module bitmap_run_allocator_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // [2:0] op, [12:3] bit_index, [23:13] bit_count
  input  wire logic [23:0]                in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [0] status, [10:1] found_index, [11] bit_value, [15:12] zero
  output logic [15:0]                     out_tdata,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [bra_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  localparam int CW = bra_pkg::CNT_W;

  logic [CW-1:0] bit_limit_r;
  logic [CW-1:0] lim;
  logic          out_valid_r;
  bra_pkg::res_t out_res_r;
  bra_pkg::cmd_t cmd;
  bra_pkg::res_t eng_res;
  logic          eng_res_valid, res_ready;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == bra_pkg::REG_LIMIT_ADR) ? {{(32-CW){1'b0}}, bit_limit_r}
                                                            : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_limit_r <= bra_pkg::NBITS_C;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == bra_pkg::REG_LIMIT_ADR) begin
      bit_limit_r <= cfg_pwdata[CW-1:0];
    end
  end

  assign lim = (bit_limit_r > bra_pkg::NBITS_C) ? bra_pkg::NBITS_C : bit_limit_r;

  assign cmd.op        = in_tdata[2:0];
  assign cmd.bit_index = in_tdata[12:3];
  assign cmd.bit_count = in_tdata[23:13];

  assign res_ready = !out_valid_r || out_tready;

  bra_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd       (cmd),
    .cmd_ready (in_tready),
    .lim       (lim),
    .res_valid (eng_res_valid),
    .res       (eng_res),
    .res_ready (res_ready)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= eng_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && eng_res_valid) begin
      out_res_r <= eng_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.bit_value, out_res_r.found_index, out_res_r.status};

endmodule
`default_nettype wire

// File: hw/rtl/bra_checker.sv
// Port-level checks for the allocator top level, bound into it.
`default_nettype none
module bra_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tvalid,
  input wire logic                       in_tready,
  input wire logic [23:0]                in_tdata,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [15:0]                out_tdata,
  input wire logic                       cfg_psel,
  input wire logic                       cfg_penable,
  input wire logic                       cfg_pwrite,
  input wire logic [bra_pkg::ADDR_W-1:0] cfg_paddr,
  input wire logic [31:0]                cfg_pwdata,
  input wire logic [31:0]                cfg_prdata,
  input wire logic                       cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[11:1] == 11'd0)
    else $error("failed allocation carries an index or bit value");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:12] == 4'd0 && cfg_pready)
    else $error("result padding not zero or config port not ready");

endmodule

bind bitmap_run_allocator_unit bra_checker u_bra_checker (.*);
`default_nettype wire
